>>> src/lpdk_pkg.sv
// ----------------------------------------------------------------------------
// lpdk_pkg
// shared types and constants for the length-prefix deframer with keepalive
// ----------------------------------------------------------------------------
package lpdk_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [CntW-1:0] CntSat = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_PING_INTERVAL = 2'd0;
  localparam logic [1:0] REG_LOST_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd2;

  localparam logic [CntW-1:0] PingIntervalRst = 16'd5;
  localparam logic [CntW-1:0] LostTimeoutRst  = 16'd15;
  localparam logic [CntW-1:0] MaxFrameLenRst  = 16'd4094;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_QUEUED  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_PING_REQ = 2'd1,
    KIND_LOST     = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef struct packed {
    logic [CntW-1:0] ping_interval;
    logic [CntW-1:0] lost_timeout;
    logic [CntW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
  } result_t;

endpackage

>>> src/length_prefix_deframer_keepalive.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_keepalive
// byte stream deframer with link keepalive and loss supervision
// ----------------------------------------------------------------------------
// datapath: an accepted beat waits in the input register and its result is
//   registered in the output register; a stalled receiver holds both
// throughput: one beat per cycle while the receiver does not stall, set by the
//   single input register feeding one combinational step into the output register
// reset: async active low, clears parser, counters, lockout and both stages;
//   config registers return to 5 / 15 / 4094
module length_prefix_deframer_keepalive (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] first_of_frame, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last_of_frame
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import lpdk_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_full_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res_frm, res_mon, res;
  logic    out_free;
  logic    consume;
  logic    in_take;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  lpdk_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held beat moves on when the output register is empty or draining
  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = in_full_q && out_free;
  assign s_axis_tready = !in_full_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (consume) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.cmd     <= cmd_e'(s_axis_tuser);
      in_item_q.rx_byte <= s_axis_tdata;
    end
  end

  // frame parser and link supervision both see every consumed beat
  lpdk_deframe u_deframe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (consume),
    .item_i          (in_item_q),
    .max_frame_len_i (cfg.max_frame_len),
    .res_o           (res_frm)
  );

  lpdk_link_mon u_link_mon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (consume),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res_mon)
  );

  // only one of them can produce a result for a given command
  assign res = (in_item_q.cmd == CMD_TICK) ? res_mon : res_frm;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && res.vld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res.vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.first, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

`ifndef SYNTHESIS
  // a pending result is never overwritten by a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && res.vld) |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while stalled");

  // a full input register takes a new beat only while it drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_full_q) |-> consume)
    else $error("input register overrun");

  // frame markers appear on payload beats only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind != KIND_DATA)) |-> (!out_q.first && !out_q.last))
    else $error("frame marker on a non-payload beat");

  // a tick only ever yields a link event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && res.vld && (in_item_q.cmd == CMD_TICK)) |=>
      (out_valid_q && ((out_q.kind == KIND_LOST) || (out_q.kind == KIND_PING_REQ))))
    else $error("tick produced a non-link result");
`endif

endmodule

>>> src/lpdk_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpdk_cfg_regs
// configuration register file, written one beat at a time
// ----------------------------------------------------------------------------
module lpdk_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [1:0]           wr_index_i,
  input  logic [15:0]          wr_data_i,
  output lpdk_pkg::cfg_t       cfg_o
);
  import lpdk_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_PING_INTERVAL: cfg_d.ping_interval = wr_data_i;
        REG_LOST_TIMEOUT:  cfg_d.lost_timeout  = wr_data_i;
        REG_MAX_FRAME_LEN: cfg_d.max_frame_len = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_interval <= PingIntervalRst;
      cfg_q.lost_timeout  <= LostTimeoutRst;
      cfg_q.max_frame_len <= MaxFrameLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lpdk_deframe.sv
// ----------------------------------------------------------------------------
// lpdk_deframe
// length-prefix frame parser with oversize lockout
// ----------------------------------------------------------------------------
module lpdk_deframe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lpdk_pkg::item_t    item_i,
  input  logic [15:0]        max_frame_len_i,
  output lpdk_pkg::result_t  res_o
);
  import lpdk_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN_LO  = 3'b001,
    PH_LEN_HI  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [CntW-1:0]   left_q, left_d;
  logic              start_q, start_d;
  logic              halted_q, halted_d;
  logic [CntW-1:0]   len;
  result_t           res;

  assign len = {item_i.rx_byte, len_lo_q};

  always_comb begin
    phase_d  = phase_q;
    len_lo_d = len_lo_q;
    left_d   = left_q;
    start_d  = start_q;
    halted_d = halted_q;
    res      = '0;
    if (en_i && (item_i.cmd == CMD_RX_BYTE) && !halted_q) begin
      case (phase_q)
        PH_LEN_LO: begin
          len_lo_d = item_i.rx_byte;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          phase_d = PH_LEN_LO;
          // zero length is a keepalive frame, nothing to pass on
          if (len != '0) begin
            if (len > max_frame_len_i) begin
              halted_d = 1'b1;
              res.vld  = 1'b1;
              res.kind = KIND_TOO_LONG;
            end else begin
              left_d  = len;
              start_d = 1'b1;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res.vld   = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = item_i.rx_byte;
          res.first = start_q;
          res.last  = (left_q == CntW'(1));
          left_d    = left_q - CntW'(1);
          start_d   = 1'b0;
          if (left_q == CntW'(1)) begin
            phase_d = PH_LEN_LO;
          end
        end
        default: begin
          len_lo_d = item_i.rx_byte;
          phase_d  = PH_LEN_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN_LO;
      len_lo_q <= '0;
      left_q   <= '0;
      start_q  <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      left_q   <= left_d;
      start_q  <= start_d;
      halted_q <= halted_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  // once locked out, no more payload leaves the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !(res.vld && (res.kind == KIND_DATA)))
    else $error("payload passed after oversize lockout");

  // payload phase always has bytes left to count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (left_q != '0))
    else $error("payload phase with zero bytes left");

  // the lockout flag never clears without reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("lockout released without reset");
`endif

endmodule

>>> src/lpdk_link_mon.sv
// ----------------------------------------------------------------------------
// lpdk_link_mon
// receive silence and send idle counters driven by the tick command
// ----------------------------------------------------------------------------
module lpdk_link_mon (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lpdk_pkg::item_t    item_i,
  input  lpdk_pkg::cfg_t     cfg_i,
  output lpdk_pkg::result_t  res_o
);
  import lpdk_pkg::*;

  logic [CntW-1:0] silence_q, silence_d;
  logic [CntW-1:0] idle_q, idle_d;
  logic [CntW-1:0] silence_inc, idle_inc;
  result_t         res;

  assign silence_inc = (silence_q == CntSat) ? CntSat : silence_q + CntW'(1);
  assign idle_inc    = (idle_q == CntSat) ? CntSat : idle_q + CntW'(1);

  always_comb begin
    silence_d = silence_q;
    idle_d    = idle_q;
    res       = '0;
    if (en_i) begin
      case (item_i.cmd)
        CMD_RX_BYTE: silence_d = '0;
        CMD_TICK: begin
          silence_d = silence_inc;
          idle_d    = idle_inc;
          // link loss wins over a keepalive request on the same tick
          if (silence_inc > cfg_i.lost_timeout) begin
            silence_d = '0;
            res.vld   = 1'b1;
            res.kind  = KIND_LOST;
          end else if (idle_inc > cfg_i.ping_interval) begin
            idle_d   = '0;
            res.vld  = 1'b1;
            res.kind = KIND_PING_REQ;
          end
        end
        CMD_QUEUED:  idle_d = '0;
        default:     silence_d = silence_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= '0;
      idle_q    <= '0;
    end else begin
      silence_q <= silence_d;
      idle_q    <= idle_d;
    end
  end

  assign res_o = res;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the deframer with byte, tick and queued-message beats, keeps its own
// copy of the parser and supervision counters, and checks every output beat
// in order against that copy or a fixed beat. Random gaps and stalls cover both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import lpdk_pkg::*;

  localparam int unsigned SettleCycles = 4;   // output lags input through the input and output registers
  localparam int unsigned NumDir       = 20;
  localparam logic [1:0]  CmdUnused    = 2'd3;

  typedef enum logic [1:0] {PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD} parse_ph_e;
  // how the expectation of a beat is formed
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BEAT} chk_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       first;
    logic       last;
  } beat_res_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx;
    chk_e       how;
    beat_res_t  res;
  } row_t;

  localparam beat_res_t NoBeat = '{KIND_DATA, 8'h00, 1'b0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // travels with each input beat
  chk_e        exp_how;
  beat_res_t   exp_fixed;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned err_cnt = 0;

  beat_res_t   pending_beats[$];

  // predicted block state
  logic [15:0] ping_lim, lost_lim, max_len;
  parse_ph_e   fr_phase;
  logic [7:0]  len_lo;
  logic [15:0] fr_left;
  logic        fr_first;
  logic [15:0] silence_cnt, idle_cnt;
  logic        halted_q;

  row_t dir_rows [0:NumDir-1] = '{
    '{CMD_QUEUED,  8'h00, CHK_NONE,  NoBeat},
    '{CmdUnused,   8'hFF, CHK_NONE,  NoBeat},
    '{CMD_RX_BYTE, 8'h01, CHK_NONE,  NoBeat},
    '{CMD_RX_BYTE, 8'h00, CHK_NONE,  NoBeat},
    '{CMD_RX_BYTE, 8'hFF, CHK_BEAT,  '{KIND_DATA, 8'hFF, 1'b1, 1'b1}},
    // zero length keepalive frame
    '{CMD_RX_BYTE, 8'h00, CHK_NONE,  NoBeat},
    '{CMD_RX_BYTE, 8'h00, CHK_NONE,  NoBeat},
    '{CMD_RX_BYTE, 8'h03, CHK_MODEL, NoBeat},
    '{CMD_RX_BYTE, 8'h00, CHK_MODEL, NoBeat},
    '{CMD_RX_BYTE, 8'h00, CHK_MODEL, NoBeat},
    '{CMD_RX_BYTE, 8'hA5, CHK_MODEL, NoBeat},
    '{CMD_RX_BYTE, 8'h5A, CHK_MODEL, NoBeat},
    // sixth tick passes the default ping interval
    '{CMD_TICK,    8'h00, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'h55, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'hAA, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'h00, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'h00, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'h00, CHK_MODEL, NoBeat},
    '{CMD_QUEUED,  8'hFF, CHK_MODEL, NoBeat},
    '{CMD_TICK,    8'h00, CHK_MODEL, NoBeat}
  };

  length_prefix_deframer_keepalive u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // one input beat through the parser and supervision counters
  function automatic logic deframe_step(input logic [1:0] cmd, input logic [7:0] rx,
                                        output beat_res_t res);
    logic [15:0] len;
    res = NoBeat;
    deframe_step = 1'b0;
    case (cmd)
      CMD_RX_BYTE: begin
        silence_cnt = '0;
        if (!halted_q) begin
          if (fr_phase == PH_PAYLOAD && fr_left != 0) begin
            res.data  = rx;
            res.first = fr_first;
            res.last  = (fr_left == 16'd1);
            fr_left   = fr_left - 16'd1;
            fr_first  = 1'b0;
            if (fr_left == 0) fr_phase = PH_LEN_LO;
            deframe_step = 1'b1;
          end else if (fr_phase == PH_LEN_HI) begin
            len      = {rx, len_lo};
            fr_phase = PH_LEN_LO;
            if (len > max_len) begin
              halted_q     = 1'b1;
              res.kind     = KIND_TOO_LONG;
              deframe_step = 1'b1;
            end else if (len != 0) begin
              fr_left  = len;
              fr_first = 1'b1;
              fr_phase = PH_PAYLOAD;
            end
          end else begin
            len_lo   = rx;
            fr_phase = PH_LEN_HI;
          end
        end
      end
      CMD_TICK: begin
        if (silence_cnt != CntSat) silence_cnt = silence_cnt + 16'd1;
        if (idle_cnt != CntSat) idle_cnt = idle_cnt + 16'd1;
        // link loss wins over a ping request on the same tick
        if (silence_cnt > lost_lim) begin
          silence_cnt  = '0;
          res.kind     = KIND_LOST;
          deframe_step = 1'b1;
        end else if (idle_cnt > ping_lim) begin
          idle_cnt     = '0;
          res.kind     = KIND_PING_REQ;
          deframe_step = 1'b1;
        end
      end
      CMD_QUEUED: idle_cnt = '0;
      default: ;
    endcase
  endfunction

  // output check first, then config and input beats of the same edge
  always @(posedge clk_i) begin : scoreboard
    logic      hit;
    beat_res_t pred;
    beat_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_beats.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 16'h0000);
        end else begin
          want = pending_beats.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("kind", {14'h0, m_axis_tuser}, {14'h0, want.kind});
          if (m_axis_tdata[7:0] !== want.data)
            report_mismatch("payload", {8'h0, m_axis_tdata[7:0]}, {8'h0, want.data});
          if (m_axis_tdata[8] !== want.first)
            report_mismatch("first", {15'h0, m_axis_tdata[8]}, {15'h0, want.first});
          if (m_axis_tlast !== want.last)
            report_mismatch("last", {15'h0, m_axis_tlast}, {15'h0, want.last});
          if (m_axis_tdata[15:9] !== 7'h00)
            report_mismatch("tdata pad", m_axis_tdata, {7'h0, m_axis_tdata[8:0]});
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PING_INTERVAL: ping_lim = cfg_data_i;
          REG_LOST_TIMEOUT:  lost_lim = cfg_data_i;
          REG_MAX_FRAME_LEN: max_len  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        hit = deframe_step(s_axis_tuser, s_axis_tdata, pred);
        case (exp_how)
          CHK_MODEL: if (hit) pending_beats = {pending_beats, pred};
          CHK_BEAT:  pending_beats = {pending_beats, exp_fixed};
          default: ;
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx,
                           input chk_e how, input beat_res_t fixed);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= rx;
    exp_how       <= how;
    exp_fixed     <= fixed;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait for every outstanding beat to come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] ping, input logic [15:0] lost,
                            input logic [15:0] maxl);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PING_INTERVAL;
    cfg_data_i  <= ping;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_LOST_TIMEOUT;
    cfg_data_i  <= lost;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_MAX_FRAME_LEN;
    cfg_data_i  <= maxl;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // finish whatever frame the parser is in, reading the predicted state once idle
  task automatic resync();
    int n;
    drain();
    if (fr_phase == PH_LEN_HI && !halted_q) begin
      send_item(CMD_RX_BYTE, 8'h00, CHK_MODEL, NoBeat);
      drain();
    end
    n = (fr_phase == PH_PAYLOAD && !halted_q) ? int'(fr_left) : 0;
    repeat (n) send_item(CMD_RX_BYTE, 8'($urandom), CHK_MODEL, NoBeat);
  endtask

  // mostly well formed frames, with tick bursts, queued messages, unused
  // commands, cut frames and stray bytes mixed in
  task automatic run_stream(input int n_items, input int len_cap, input int burst_cap,
                            input bit stray_ok);
    int sent;
    int len;
    int k;
    int pick;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, len_cap);
        if (stray_ok && $urandom_range(0, 29) == 0) len = $urandom_range(256, 262);
        send_item(CMD_RX_BYTE, len[7:0], CHK_MODEL, NoBeat);
        send_item(CMD_RX_BYTE, len[15:8], CHK_MODEL, NoBeat);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_QUEUED,
                      8'($urandom), CHK_MODEL, NoBeat);
          if ($urandom_range(0, 39) == 0) break;
          send_item(CMD_RX_BYTE, 8'($urandom), CHK_MODEL, NoBeat);
        end
        sent += len + 2;
        if (k < len) resync();
      end else if (pick < 75) begin
        len = $urandom_range(1, burst_cap);
        repeat (len) send_item(CMD_TICK, 8'($urandom), CHK_MODEL, NoBeat);
        sent += len;
      end else if (pick < 85) begin
        send_item(CMD_QUEUED, 8'($urandom), CHK_MODEL, NoBeat);
        sent++;
      end else if (pick < 92) begin
        send_item(CmdUnused, 8'($urandom), CHK_MODEL, NoBeat);
      end else if (stray_ok) begin
        // lone byte between frames becomes the low length byte
        send_item(CMD_RX_BYTE, 8'($urandom), CHK_MODEL, NoBeat);
        resync();
        sent++;
      end else begin
        send_item(CMD_TICK, 8'($urandom), CHK_MODEL, NoBeat);
        sent++;
      end
    end
  endtask

  initial begin
    ping_lim    = PingIntervalRst;
    lost_lim    = LostTimeoutRst;
    max_len     = MaxFrameLenRst;
    fr_phase    = PH_LEN_LO;
    len_lo      = '0;
    fr_left     = '0;
    fr_first    = 1'b0;
    silence_cnt = '0;
    idle_cnt    = '0;
    halted_q    = 1'b0;
    gap_pct     = 9;
    stall_pct   = 57;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_RX_BYTE;
    exp_how       <= CHK_MODEL;
    exp_fixed     <= NoBeat;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_PING_INTERVAL;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender rarely idle, receiver stalls often
    for (int i = 0; i < NumDir; i++)
      send_item(dir_rows[i].cmd, dir_rows[i].rx, dir_rows[i].how, dir_rows[i].res);
    run_stream(200, 10, 20, 1'b1);
    drain();
    set_limits(16'd1, 16'd2, 16'd8);
    run_stream(200, 8, 4, 1'b0);

    // sender idle often, receiver rarely stalls
    drain();
    gap_pct   = 57;
    stall_pct = 9;
    set_limits(16'd65535, 16'd1, 16'd1);
    run_stream(200, 1, 3, 1'b0);
    drain();
    set_limits(16'd2, 16'd7, 16'd20);
    run_stream(200, 12, 10, 1'b0);

    // full rate on both sides
    drain();
    gap_pct   = 0;
    stall_pct = 0;
    set_limits(16'd3, 16'd65535, 16'd65535);
    run_stream(200, 10, 6, 1'b1);

    // one past the frame limit locks the parser for the rest of the run
    drain();
    set_limits(16'd2, 16'd3, 16'd4);
    run_stream(60, 4, 5, 1'b0);
    send_item(CMD_RX_BYTE, 8'h05, CHK_MODEL, NoBeat);
    send_item(CMD_RX_BYTE, 8'h00, CHK_MODEL, NoBeat);
    run_stream(80, 6, 5, 1'b0);
    drain();

    if (pending_beats.size() != 0)
      report_mismatch("beats never seen", 16'(pending_beats.size()), 16'h0000);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
